// ===== rtl/eatp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eatp_pkg
// Types and constants for the back-EMF angle tracking PLL.
// ----------------------------------------------------------------------------
package eatp_pkg;

	typedef struct packed {
		logic               mode;
		logic signed [15:0] emf_a;
		logic signed [15:0] emf_b;
		logic signed [31:0] preset_angle;
		logic signed [31:0] preset_speed;
	} eatp_in_t;

	typedef struct packed {
		logic signed [31:0] angle;
		logic signed [31:0] flux_angle;
		logic signed [31:0] speed;
		logic               updated;
	} eatp_out_t;

	localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
	localparam logic [2:0] REG_EMF_THRESH = 3'd2;
	localparam logic [2:0] REG_SPEED_LIM  = 3'd3;
	localparam logic [2:0] REG_INTEG_LIM  = 3'd4;

	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam int CORDIC_STEPS = 16;

	function automatic logic [31:0] atan_lut(input logic [3:0] i);
		case (i)
			4'd0:  atan_lut = 32'd536870912;
			4'd1:  atan_lut = 32'd316933406;
			4'd2:  atan_lut = 32'd167458907;
			4'd3:  atan_lut = 32'd85004756;
			4'd4:  atan_lut = 32'd42667331;
			4'd5:  atan_lut = 32'd21354465;
			4'd6:  atan_lut = 32'd10679838;
			4'd7:  atan_lut = 32'd5340245;
			4'd8:  atan_lut = 32'd2670163;
			4'd9:  atan_lut = 32'd1335087;
			4'd10: atan_lut = 32'd667544;
			4'd11: atan_lut = 32'd333772;
			4'd12: atan_lut = 32'd166886;
			4'd13: atan_lut = 32'd83443;
			4'd14: atan_lut = 32'd41722;
			default: atan_lut = 32'd20861;
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== rtl/emf_angle_tracking_pll.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Work: a preset transfer goes straight to the result; an update runs the
//   square root and stops there if the root is zero or below the threshold,
//   else it runs two divides, the CORDIC rotation and multiply and clamp steps.
// Flow: in_stall stays high while an item is in work or its result
//   waits; the next input transfer can come in the cycle after the output transfer.
// Reset: angle, speed and integrator clear; registers take reset values.
// ----------------------------------------------------------------------------
// emf_angle_tracking_pll
// Back-EMF PLL with a shared iterative square root, divider and CORDIC.
// ----------------------------------------------------------------------------
module emf_angle_tracking_pll (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 psel,
	input  wire                 penable,
	input  wire                 pwrite,
	input  wire  [4:0]          paddr,
	input  wire  [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  wire                 in_valid,
	output logic                in_stall,
	input  eatp_pkg::eatp_in_t  in_data,
	output logic                out_valid,
	input  wire                 out_stall,
	output eatp_pkg::eatp_out_t out_data
);
	import eatp_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_SQRT  = 11'b00000000010,
		ST_CHK   = 11'b00000000100,
		ST_DIVA  = 11'b00000001000,
		ST_DIVB  = 11'b00000010000,
		ST_COR   = 11'b00000100000,
		ST_MUL   = 11'b00001000000,
		ST_ERR   = 11'b00010000000,
		ST_INT   = 11'b00100000000,
		ST_SPD   = 11'b01000000000,
		ST_OUT   = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [30:0] prop_gain_q, integ_gain_q, speed_lim_q, integ_lim_q;
	logic [14:0] thresh_q;
	logic [31:0] angle_q;
	logic signed [31:0] speed_q, integ_q;
	logic [4:0]  cnt_q;
	logic signed [15:0] ea_q, eb_q;
	logic [31:0] rad_q, rem_q, root_q;
	logic [14:0] mag_q;
	logic [31:0] dnum_q, drem_q, dquo_q;
	logic        dneg_q;
	logic signed [16:0] na_q, nb_q;
	logic signed [33:0] cx_q, cy_q;
	logic signed [32:0] cz_q;
	logic        cneg_q;
	logic signed [15:0] s_q, c_q;
	logic signed [33:0] p1_q, p2_q;
	logic signed [31:0] err_q;
	logic signed [63:0] pm_q, im_q;
	logic        upd_q;
	eatp_out_t   out_q;

	logic wr;
	logic [2:0] ridx;
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign ridx = paddr[4:2];

	always_comb begin
		case (ridx)
			REG_PROP_GAIN:  prdata = {1'b0, prop_gain_q};
			REG_INTEG_GAIN: prdata = {1'b0, integ_gain_q};
			REG_EMF_THRESH: prdata = {17'd0, thresh_q};
			REG_SPEED_LIM:  prdata = {1'b0, speed_lim_q};
			REG_INTEG_LIM:  prdata = {1'b0, integ_lim_q};
			default:        prdata = 32'd0;
		endcase
	end

	// sqrt step
	logic [31:0] sq_trial, bitv;
	logic [31:0] sq_rem_n, sq_root_n;
	always_comb begin
		bitv = 32'd1 << {cnt_q[3:0], 1'b0};
		sq_trial = root_q + bitv;
		if (rem_q >= sq_trial) begin
			sq_rem_n = rem_q - sq_trial;
			sq_root_n = (root_q >> 1) + bitv;
		end else begin
			sq_rem_n = rem_q;
			sq_root_n = root_q >> 1;
		end
	end

	// restoring divide step, dividend <= 2^30, divisor 15 bits
	logic [31:0] dv_shift;
	logic [15:0] dq_n;
	always_comb dv_shift = {drem_q[30:0], dnum_q[31]};
	always_comb dq_n = {dquo_q[14:0], dv_shift >= {17'd0, mag_q}};

	// cordic step
	logic signed [33:0] cdx, cdy;
	logic signed [32:0] catan;
	always_comb begin
		cdx = cy_q >>> cnt_q[3:0];
		cdy = cx_q >>> cnt_q[3:0];
		catan = $signed({1'b0, atan_lut(cnt_q[3:0])});
	end

	function automatic logic signed [15:0] rq15(input logic signed [33:0] v);
		logic signed [33:0] r;
		r = (v + 34'sd16384) >>> 15;
		if (r > 34'sd32767) rq15 = 16'sh7fff;
		else if (r < -34'sd32768) rq15 = 16'sh8000;
		else rq15 = r[15:0];
	endfunction

	function automatic logic signed [31:0] clamp33(input logic signed [33:0] v,
		input logic [30:0] lim);
		logic signed [33:0] l;
		l = $signed({3'b0, lim});
		if (v > l) clamp33 = $signed({1'b0, lim});
		else if (v < -l) clamp33 = -$signed({1'b0, lim});
		else clamp33 = v[31:0];
	endfunction

	logic signed [33:0] int_sum, spd_sum;
	logic signed [31:0] int_n, spd_n, pre_sp;
	always_comb begin
		int_sum = 34'(integ_q) + 34'(im_q >>> 15);
		int_n = clamp33(int_sum, integ_lim_q);
		spd_sum = 34'(pm_q >>> 15) + 34'(integ_q);
		spd_n = clamp33(spd_sum, speed_lim_q);
		pre_sp = clamp33(34'(in_data.preset_speed), speed_lim_q);
	end

	logic [31:0] fold;
	logic [15:0] absa, absb;
	always_comb begin
		fold = angle_q + QUARTER_TURN;
		absa = ea_q[15] ? 16'(-ea_q) : ea_q;
		absb = eb_q[15] ? 16'(-eb_q) : eb_q;
	end

	assign in_stall = (state_q != ST_IDLE) || out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prop_gain_q <= '0;
			integ_gain_q <= '0;
			thresh_q <= 15'd1;
			speed_lim_q <= 31'h7fffffff;
			integ_lim_q <= 31'h7fffffff;
			angle_q <= '0;
			speed_q <= '0;
			integ_q <= '0;
			out_valid <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				case (ridx)
					REG_PROP_GAIN:  prop_gain_q <= pwdata[30:0];
					REG_INTEG_GAIN: integ_gain_q <= pwdata[30:0];
					REG_EMF_THRESH: thresh_q <= pwdata[14:0];
					REG_SPEED_LIM:  speed_lim_q <= pwdata[30:0];
					REG_INTEG_LIM:  integ_lim_q <= pwdata[30:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid && !in_stall) begin
					if (in_data.mode) begin
						angle_q <= in_data.preset_angle;
						speed_q <= pre_sp;
						integ_q <= clamp33(34'(pre_sp), integ_lim_q);
						upd_q <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						ea_q <= in_data.emf_a;
						eb_q <= in_data.emf_b;
						rad_q <= 32'(in_data.emf_a * in_data.emf_a)
							+ 32'(in_data.emf_b * in_data.emf_b);
						cnt_q <= 5'd15;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (cnt_q == 5'd15) begin
						rem_q <= rad_q;
						root_q <= '0;
						cnt_q <= 5'd14;
						if (rad_q >= 32'h4000_0000) begin
							rem_q <= rad_q - 32'h4000_0000;
							root_q <= 32'h4000_0000;
						end
					end else begin
						rem_q <= sq_rem_n;
						root_q <= sq_root_n;
						if (cnt_q == 5'd0) state_q <= ST_CHK;
						else cnt_q <= cnt_q - 5'd1;
					end
				end
				ST_CHK: begin
					mag_q <= (root_q > 32'd32767) ? 15'h7fff : root_q[14:0];
					if (root_q == 32'd0 || (root_q < 32'd32767 && root_q[14:0] < thresh_q)) begin
						upd_q <= 1'b0;
						state_q <= ST_OUT;
					end else begin
						dnum_q <= {1'b0, absa, 15'd0};
						dneg_q <= ea_q[15];
						drem_q <= '0;
						cnt_q <= 5'd31;
						state_q <= ST_DIVA;
					end
				end
				ST_DIVA, ST_DIVB: begin
					dnum_q <= {dnum_q[30:0], 1'b0};
					if (dv_shift >= {17'd0, mag_q}) begin
						drem_q <= dv_shift - {17'd0, mag_q};
						dquo_q <= {dquo_q[30:0], 1'b1};
					end else begin
						drem_q <= dv_shift;
						dquo_q <= {dquo_q[30:0], 1'b0};
					end
					if (cnt_q != 5'd31 || 1'b1) cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						cnt_q <= 5'd31;
						drem_q <= '0;
						if (state_q == ST_DIVA) begin
							dnum_q <= {1'b0, absb, 15'd0};
							dneg_q <= eb_q[15];
							state_q <= ST_DIVB;
						end else begin
							cnt_q <= '0;
							cx_q <= CORDIC_GAIN;
							cy_q <= '0;
							cneg_q <= fold[31];
							cz_q <= fold[31] ? $signed({angle_q[31] ^ 1'b1, angle_q[31] ^ 1'b1,
								angle_q[30:0]}) : $signed({angle_q[31], angle_q});
							state_q <= ST_COR;
						end
					end
				end
				ST_COR: begin
					if (cz_q >= 0) begin
						cx_q <= cx_q - cdx;
						cy_q <= cy_q + cdy;
						cz_q <= cz_q - catan;
					end else begin
						cx_q <= cx_q + cdx;
						cy_q <= cy_q - cdy;
						cz_q <= cz_q + catan;
					end
					if (cnt_q == 5'(CORDIC_STEPS - 1)) state_q <= ST_MUL;
					else cnt_q <= cnt_q + 5'd1;
				end
				ST_MUL: begin
					c_q <= rq15(cneg_q ? -cx_q : cx_q);
					s_q <= rq15(cneg_q ? -cy_q : cy_q);
					state_q <= ST_ERR;
				end
				ST_ERR: begin
					if (cnt_q[4] == 1'b0) begin
						p1_q <= 34'(na_q) * 34'(s_q);
						p2_q <= 34'(nb_q) * 34'(c_q);
						cnt_q <= 5'd16;
					end else begin
						err_q <= 32'((p2_q - p1_q) >>> 15);
						state_q <= ST_INT;
					end
				end
				ST_INT: begin
					im_q <= $signed({33'd0, integ_gain_q}) * 64'(err_q);
					pm_q <= $signed({33'd0, prop_gain_q}) * 64'(err_q);
					state_q <= ST_SPD;
				end
				ST_SPD: begin
					if (cnt_q == 5'd16) begin
						integ_q <= int_n;
						cnt_q <= 5'd17;
					end else begin
						speed_q <= spd_n;
						angle_q <= angle_q + spd_n;
						upd_q <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					out_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// quotient capture
	always_ff @(posedge clk) begin
		if ((state_q == ST_DIVA || state_q == ST_DIVB) && cnt_q == 5'd0) begin
			if (state_q == ST_DIVA)
				na_q <= dneg_q ? -$signed({1'b0, dq_n}) : $signed({1'b0, dq_n});
			else
				nb_q <= dneg_q ? -$signed({1'b0, dq_n}) : $signed({1'b0, dq_n});
		end
	end

	always_comb begin
		out_q.angle = angle_q;
		out_q.flux_angle = speed_q[31] ? angle_q + QUARTER_TURN : angle_q - QUARTER_TURN;
		out_q.speed = speed_q;
		out_q.updated = upd_q;
	end
	assign out_data = out_q;

endmodule
`default_nettype wire

// ===== tb/emf_angle_tracking_pll_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emf_angle_tracking_pll_tb
// Drives EMF and preset transfers through the PLL under several register
// settings and random idling, predicts each result with a local model of the
// tracking loop and compares every output transfer field by field.
// ----------------------------------------------------------------------------
module emf_angle_tracking_pll_tb;
	import eatp_pkg::*;

	localparam logic MODE_UPDATE = 1'b0;
	localparam logic MODE_PRESET = 1'b1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	eatp_in_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	eatp_out_t   out_data;

	emf_angle_tracking_pll i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always #5 clk = ~clk;

	// tracker state and registers
	logic [31:0]        pll_angle;
	logic signed [31:0] pll_speed, pll_integ;
	logic [30:0]        kp, ki, spd_lim, int_lim;
	logic [14:0]        emf_thr;

	eatp_out_t expected_q[$];
	int        fail_cnt = 0;
	int        hold_cycles = 0;
	bit        burst_mode = 1'b1;

	function automatic longint asr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint clamp_sym(longint v, logic [30:0] lim);
		longint l;
		l = longint'(lim);
		if (v > l) return l;
		if (v < -l) return -l;
		return v;
	endfunction

	function automatic int unsigned isqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return 32'(r);
	endfunction

	function automatic longint to_q15(longint v);
		longint r;
		r = asr(v + 16384, 15);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r;
	endfunction

	function automatic int atan_value(int i);
		int t[16] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772,
			166886, 83443, 41722, 20861};
		return t[i];
	endfunction

	function automatic void sincos(logic [31:0] a, output longint s, output longint c);
		longint x, y, z, nx, dx, dy, at;
		bit neg;
		x = 652032874;
		y = 0;
		neg = 1'b0;
		if (((a + QUARTER_TURN) & 32'h8000_0000) != 0) begin
			a ^= 32'h8000_0000;
			neg = 1'b1;
		end
		z = longint'($signed(a));
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = asr(y, i);
			dy = asr(x, i);
			at = longint'(atan_value(i));
			if (z >= 0) begin
				nx = x - dx; y = y + dy; z -= at;
			end else begin
				nx = x + dx; y = y - dy; z += at;
			end
			x = nx;
		end
		if (neg) begin
			x = -x; y = -y;
		end
		c = to_q15(x);
		s = to_q15(y);
	endfunction

	function automatic eatp_out_t track_step(eatp_in_t it);
		eatp_out_t  r;
		longint     ea, eb, na, nb, s, c, err, acc, sp;
		int unsigned mag;
		r.updated = 1'b0;
		if (it.mode == MODE_PRESET) begin
			sp = clamp_sym(longint'(it.preset_speed), spd_lim);
			pll_angle = it.preset_angle;
			pll_speed = 32'(sp);
			pll_integ = 32'(clamp_sym(sp, int_lim));
			r.updated = 1'b1;
		end else begin
			ea = it.emf_a;
			eb = it.emf_b;
			mag = isqrt(longint'(ea * ea + eb * eb));
			if (mag > 32767) mag = 32767;
			if (mag != 0 && mag >= emf_thr) begin
				na = (ea * 32768) / longint'(mag);
				nb = (eb * 32768) / longint'(mag);
				sincos(pll_angle, s, c);
				err = longint'($signed(32'(asr(-na * s + nb * c, 15))));
				acc = longint'(pll_integ) + asr(longint'(ki) * err, 15);
				acc = clamp_sym(acc, int_lim);
				pll_integ = 32'(acc);
				sp = clamp_sym(asr(longint'(kp) * err, 15) + acc, spd_lim);
				pll_speed = 32'(sp);
				pll_angle = pll_angle + 32'(sp);
				r.updated = 1'b1;
			end
		end
		r.angle = pll_angle;
		r.flux_angle = (pll_speed >= 0) ? pll_angle - QUARTER_TURN : pll_angle + QUARTER_TURN;
		r.speed = pll_speed;
		return r;
	endfunction

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		logic [31:0] rd_exp;
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_PROP_GAIN:  kp = val[30:0];
			REG_INTEG_GAIN: ki = val[30:0];
			REG_EMF_THRESH: emf_thr = val[14:0];
			REG_SPEED_LIM:  spd_lim = val[30:0];
			REG_INTEG_LIM:  int_lim = val[30:0];
			default: ;
		endcase
		rd_exp = (idx == REG_EMF_THRESH) ? {17'd0, val[14:0]} : {1'b0, val[30:0]};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== rd_exp) begin
			$error("prdata exp %h got %h", rd_exp, prdata);
			fail_cnt++;
		end
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0;
	endtask

	task automatic set_loop(logic [31:0] p, logic [31:0] i, logic [31:0] th,
		logic [31:0] sl, logic [31:0] il);
		reg_write(REG_PROP_GAIN, p);
		reg_write(REG_INTEG_GAIN, i);
		reg_write(REG_EMF_THRESH, th);
		reg_write(REG_SPEED_LIM, sl);
		reg_write(REG_INTEG_LIM, il);
	endtask

	// sender: on a falling edge, present one transfer and hold until taken
	task automatic send_item(eatp_in_t it);
		@(negedge clk);
		if (burst_mode && $urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 12)) @(negedge clk);
		in_data <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		expected_q.push_back(track_step(it));
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	function automatic eatp_in_t emf_item(int a, int b);
		eatp_in_t it;
		it.mode = MODE_UPDATE;
		it.emf_a = 16'(a);
		it.emf_b = 16'(b);
		it.preset_angle = $urandom;
		it.preset_speed = $urandom;
		return it;
	endfunction

	function automatic eatp_in_t preset_item(logic [31:0] ang, logic [31:0] spd);
		eatp_in_t it;
		it.mode = MODE_PRESET;
		it.emf_a = 16'($urandom);
		it.emf_b = 16'($urandom);
		it.preset_angle = ang;
		it.preset_speed = spd;
		return it;
	endfunction

	function automatic eatp_in_t random_item();
		int a, b, amp;
		logic [31:0] ph;
		if ($urandom_range(0, 9) == 0)
			return preset_item($urandom, $urandom);
		if ($urandom_range(0, 9) == 0)
			return emf_item($urandom_range(0, 65535), $urandom_range(0, 65535));
		amp = $urandom_range(0, 3) == 0 ? $urandom_range(0, 400) : $urandom_range(1000, 32767);
		ph = $urandom;
		a = int'($signed(16'($urandom_range(0, 65535)))) * amp / 32768;
		b = int'($signed(16'($urandom_range(0, 65535)))) * amp / 32768;
		if (ph[0]) a = -a;
		return emf_item(a, b);
	endfunction

	task automatic test_reset_defaults;
		send_item(emf_item(0, 0));
		send_item(emf_item(16'sh7fff, 0));
		send_item(emf_item(-32768, -32768));
		drain();
	endtask

	task automatic test_directed;
		set_loop(32'd40000, 32'd3000, 32'd200, 32'h0100_0000, 32'h0080_0000);
		send_item(preset_item(32'h7fff_ffff, 32'h7fff_ffff));
		send_item(preset_item(32'h8000_0000, 32'h8000_0000));
		send_item(preset_item(32'h0, 32'hffff_ffff));
		send_item(emf_item(32767, 32767));
		send_item(emf_item(-32768, 32767));
		send_item(emf_item(32767, -32768));
		send_item(emf_item(-32768, -32768));
		send_item(emf_item(199, 0));
		send_item(emf_item(0, 200));
		send_item(emf_item(0, 0));
		send_item(emf_item(-1, 1));
		send_item(preset_item(32'hc000_0000, 32'd1000));
		send_item(emf_item(20000, -15000));
		drain();
		set_loop(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		send_item(emf_item(0, 0));
		send_item(emf_item(1, 0));
		send_item(preset_item(32'h1234_5678, 32'h7000_0000));
		send_item(emf_item(-5000, 7000));
		drain();
	endtask

	task automatic test_random_phase(int n);
		for (int k = 0; k < n; k++) send_item(random_item());
		drain();
	endtask

	task automatic test_backpressure;
		hold_cycles = 400;
		burst_mode = 1'b0;
		for (int k = 0; k < 8; k++) send_item(random_item());
		burst_mode = 1'b1;
		drain();
	endtask

	// receiver stall pattern, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else
			out_stall <= ($urandom_range(0, 3) == 0);
	end

	always @(posedge clk) begin
		eatp_out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("unexpected output transfer");
				fail_cnt++;
			end else begin
				e = expected_q.pop_front();
				if (out_data.angle !== e.angle) begin
					$error("angle exp %h got %h", e.angle, out_data.angle);
					fail_cnt++;
				end
				if (out_data.flux_angle !== e.flux_angle) begin
					$error("flux_angle exp %h got %h", e.flux_angle, out_data.flux_angle);
					fail_cnt++;
				end
				if (out_data.speed !== e.speed) begin
					$error("speed exp %h got %h", e.speed, out_data.speed);
					fail_cnt++;
				end
				if (out_data.updated !== e.updated) begin
					$error("updated exp %b got %b", e.updated, out_data.updated);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		pll_angle = '0; pll_speed = '0; pll_integ = '0;
		kp = '0; ki = '0; emf_thr = 15'd1;
		spd_lim = 31'h7fff_ffff; int_lim = 31'h7fff_ffff;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_directed();
		set_loop(32'd30000, 32'd2000, 32'd500, 32'h0200_0000, 32'h0100_0000);
		test_random_phase(300);
		set_loop(32'h7fff_ffff, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'h7fff_ffff);
		test_random_phase(200);
		set_loop(32'd800, 32'd50, 32'h7fff, 32'd70000, 32'd30000);
		test_random_phase(150);
		set_loop(32'd100000, 32'd8000, 32'd0, 32'h0400_0000, 32'h0200_0000);
		test_backpressure();
		test_random_phase(170);
		if (fail_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
